// ----- sv/ipcsc_pkg.sv -----
// Package for the IPv4 classful subnet classifier.
// Holds the address constants, the mode codes, the beat type that runs along the
// cell chain and the class helper functions. No dependencies.
package ipcsc_pkg;

   localparam int unsigned NUM_INTERFACES_DEFAULT = 8;

   localparam logic [31:0] CLASS_A_NET_MASK  = 32'hFF00_0000;
   localparam logic [31:0] CLASS_B_NET_MASK  = 32'hFFFF_0000;
   localparam logic [31:0] CLASS_C_NET_MASK  = 32'hFFFF_FF00;
   localparam logic [31:0] CLASS_A_HOST_MASK = 32'h00FF_FFFF;
   localparam logic [31:0] CLASS_B_HOST_MASK = 32'h0000_FFFF;
   localparam logic [31:0] CLASS_C_HOST_MASK = 32'h0000_00FF;
   localparam logic [7:0]  LOOPBACK_NET      = 8'd127;
   localparam logic [31:0] ADDR_ANY          = 32'h0000_0000;
   localparam logic [31:0] ADDR_ALL_ONES     = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      MODE_LOAD     = 2'd0,
      MODE_CLASSIFY = 2'd1,
      MODE_COMPOSE  = 2'd2
   } mode_type;

   typedef struct packed {
      logic        valid;
      mode_type    mode;
      logic [2:0]  slot;
      logic [31:0] address;
      logic [31:0] subnet_mask;
      logic [31:0] host_bits;
      logic        broadcast_capable;
      logic        entry_enable;
      logic [31:0] class_mask;
      logic        hit;
      logic [31:0] hit_mask;
      logic        local_hit;
      logic        bcast_hit;
   } beat_type;

   function automatic logic is_class_a(input logic [31:0] a);
      return a[31] == 1'b0;
   endfunction

   function automatic logic is_class_b(input logic [31:0] a);
      return a[31:30] == 2'b10;
   endfunction

   function automatic logic is_class_c(input logic [31:0] a);
      return a[31:29] == 3'b110;
   endfunction

   function automatic logic is_class_e(input logic [31:0] a);
      return a[31:28] == 4'b1111;
   endfunction

   function automatic logic [31:0] class_net_mask(input logic [31:0] a);
      logic [31:0] m;
      if (is_class_a(a)) begin
         m = CLASS_A_NET_MASK;
      end else if (is_class_b(a)) begin
         m = CLASS_B_NET_MASK;
      end else begin
         m = CLASS_C_NET_MASK;
      end
      return m;
   endfunction

endpackage

// ----- sv/ipcsc_cell.sv -----
// One interface entry of the classifier chain plus the beat register after it.
// Captures loads addressed to its slot and folds its match into passing beats.
// Depends on ipcsc_pkg.
module ipcsc_cell
   import ipcsc_pkg::*;
#(
   parameter int unsigned INDEX = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     subnets_local,
   input  beat_type beat_i,
   output beat_type beat_o
);

   logic        entry_valid_ff;
   logic        entry_bcast_ok_ff;
   logic [31:0] entry_address_ff;
   logic [31:0] entry_class_mask_ff;
   logic [31:0] entry_subnet_mask_ff;
   beat_type    beat_ff;
   beat_type    beat_in;

   logic        load_hit;
   logic [31:0] ea_net;
   logic [31:0] ea_sub;
   logic        net_match;
   logic        sub_match;
   logic        lookup_match;
   logic        bcast_form;

   assign load_hit = beat_i.valid && (beat_i.mode == MODE_LOAD) &&
                     (32'(beat_i.slot) == 32'(INDEX));

   assign ea_net    = entry_address_ff & entry_class_mask_ff;
   assign ea_sub    = entry_address_ff & entry_subnet_mask_ff;
   assign net_match = (beat_i.address & entry_class_mask_ff) == ea_net;
   assign sub_match = (beat_i.address & entry_subnet_mask_ff) == ea_sub;

   always_comb begin
      if (beat_i.mode == MODE_COMPOSE) begin
         lookup_match = net_match;
      end else begin
         lookup_match = (beat_i.address & beat_i.class_mask) == ea_net;
      end
   end

   assign bcast_form = (beat_i.address == ea_net) ||
                       (beat_i.address == ea_sub) ||
                       (beat_i.address == (entry_address_ff | ~entry_class_mask_ff)) ||
                       (beat_i.address == (entry_address_ff | ~entry_subnet_mask_ff));

   always_comb begin
      beat_in = beat_i;
      if (entry_valid_ff && lookup_match && !beat_i.hit) begin
         beat_in.hit      = 1'b1;
         beat_in.hit_mask = entry_subnet_mask_ff;
      end
      if (entry_valid_ff && (subnets_local ? net_match : sub_match)) begin
         beat_in.local_hit = 1'b1;
      end
      if (entry_valid_ff && entry_bcast_ok_ff && bcast_form) begin
         beat_in.bcast_hit = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff    <= 1'b0;
         entry_bcast_ok_ff <= 1'b0;
      end else if (advance && load_hit) begin
         entry_valid_ff    <= beat_i.entry_enable;
         entry_bcast_ok_ff <= beat_i.broadcast_capable;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load_hit) begin
         entry_address_ff     <= beat_i.address;
         entry_class_mask_ff  <= beat_i.class_mask;
         entry_subnet_mask_ff <= beat_i.subnet_mask | beat_i.class_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (advance) begin
         beat_ff <= beat_in;
      end
   end

   assign beat_o = beat_ff;

endmodule

// ----- sv/ipcsc_out.sv -----
// Result stage of the classifier: turns the beat leaving the chain into the
// response fields and holds them until taken. Drives the chain's advance.
// Depends on ipcsc_pkg.
module ipcsc_out
   import ipcsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  beat_type    beat_i,
   input  logic        rsp_stall,
   output logic        advance,
   output logic        rsp_valid,
   output logic [31:0] rsp_network_number,
   output logic [31:0] rsp_host_number,
   output logic        rsp_is_local,
   output logic        rsp_is_broadcast,
   output logic        rsp_can_forward,
   output logic [31:0] rsp_composed_address
);

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] network_ff;
   logic [31:0] network_in;
   logic [31:0] host_ff;
   logic [31:0] host_in;
   logic        local_ff;
   logic        local_in;
   logic        bcast_ff;
   logic        bcast_in;
   logic        forward_ff;
   logic        forward_in;
   logic [31:0] composed_ff;
   logic [31:0] composed_in;

   logic [31:0] a;
   logic [31:0] cm;
   logic [31:0] hm;
   logic        abc;

   assign advance = !(rsp_valid_ff && rsp_stall);

   assign a   = beat_i.address;
   assign cm  = beat_i.class_mask;
   assign abc = is_class_a(a) || is_class_b(a) || is_class_c(a);
   assign hm  = beat_i.hit ? ~beat_i.hit_mask : ~cm;

   always_comb begin
      network_in  = '0;
      host_in     = '0;
      local_in    = 1'b0;
      bcast_in    = 1'b0;
      forward_in  = 1'b0;
      composed_in = '0;
      if (beat_i.mode == MODE_CLASSIFY) begin
         if (!abc) begin
            host_in = a;
         end else if (beat_i.hit) begin
            network_in = a & beat_i.hit_mask;
            host_in    = a & ~cm & ~beat_i.hit_mask;
         end else begin
            network_in = a & cm;
            host_in    = a & ~cm;
         end
         local_in   = beat_i.local_hit;
         bcast_in   = beat_i.bcast_hit || (a == ADDR_ANY) || (a == ADDR_ALL_ONES);
         forward_in = !is_class_e(a) &&
                      !(is_class_a(a) && ((a[31:24] == 8'd0) || (a[31:24] == LOOPBACK_NET)));
      end else if (beat_i.mode == MODE_COMPOSE) begin
         composed_in = a | (beat_i.host_bits & hm);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = beat_i.valid && (beat_i.mode != MODE_LOAD);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         network_ff  <= network_in;
         host_ff     <= host_in;
         local_ff    <= local_in;
         bcast_ff    <= bcast_in;
         forward_ff  <= forward_in;
         composed_ff <= composed_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_network_number   = network_ff;
   assign rsp_host_number      = host_ff;
   assign rsp_is_local         = local_ff;
   assign rsp_is_broadcast     = bcast_ff;
   assign rsp_can_forward      = forward_ff;
   assign rsp_composed_address = composed_ff;

   a_compose_flags_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (composed_ff != 32'd0) |->
         !local_ff && !bcast_ff && !forward_ff && (network_ff == 32'd0) && (host_ff == 32'd0))
      else $error("compose beat carries classify fields");

   a_net_host_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((network_ff & host_ff) == 32'd0))
      else $error("network and host parts overlap");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("response valid right after reset");

   a_rise_from_chain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(beat_i.valid) && ($past(beat_i.mode) != MODE_LOAD))
      else $error("response without a classify or compose beat");

endmodule

// ----- sv/ipv4_classful_subnet_classifier.sv -----
// IPv4 classful subnet classifier. Each beat runs through a chain of one cell per
// interface entry and then a result register, and one beat is accepted every cycle
// as long as the response is taken; while a response waits under rsp_stall the whole
// chain holds and req_stall is high. Loads travel the same chain and take effect at
// their cell, so every beat sees exactly the loads accepted before it. Load beats and
// beats with an unused mode give no response.
// Depends on ipcsc_pkg, ipcsc_cell, ipcsc_out.
module ipv4_classful_subnet_classifier
   import ipcsc_pkg::*;
#(
   parameter int unsigned NUM_INTERFACES = NUM_INTERFACES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [2:0]  req_entry_slot,
   input  logic [31:0] req_address,
   input  logic [31:0] req_subnet_mask,
   input  logic [31:0] req_host_bits,
   input  logic        req_broadcast_capable,
   input  logic        req_entry_enable,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_network_number,
   output logic [31:0] rsp_host_number,
   output logic        rsp_is_local,
   output logic        rsp_is_broadcast,
   output logic        rsp_can_forward,
   output logic [31:0] rsp_composed_address
);

   logic     subnets_local_ff;
   logic     advance;
   beat_type chain [NUM_INTERFACES + 1];

   always_ff @(posedge clock) begin
      if (reset) begin
         subnets_local_ff <= 1'b1;
      end else if (csr_write_enable) begin
         subnets_local_ff <= csr_write_data;
      end
   end

   assign req_stall = !advance;

   always_comb begin
      chain[0].valid             = req_valid && ((req_mode == MODE_LOAD) ||
                                   (req_mode == MODE_CLASSIFY) ||
                                   (req_mode == MODE_COMPOSE));
      chain[0].mode              = mode_type'(req_mode);
      chain[0].slot              = req_entry_slot;
      chain[0].address           = req_address;
      chain[0].subnet_mask       = req_subnet_mask;
      chain[0].host_bits         = req_host_bits;
      chain[0].broadcast_capable = req_broadcast_capable;
      chain[0].entry_enable      = req_entry_enable;
      chain[0].class_mask        = class_net_mask(req_address);
      chain[0].hit               = 1'b0;
      chain[0].hit_mask          = '0;
      chain[0].local_hit         = 1'b0;
      chain[0].bcast_hit         = 1'b0;
   end

   for (genvar i = 0; i < NUM_INTERFACES; i++) begin : g_cell
      ipcsc_cell #(
         .INDEX (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .advance       (advance),
         .subnets_local (subnets_local_ff),
         .beat_i        (chain[i]),
         .beat_o        (chain[i + 1])
      );
   end

   ipcsc_out u_out (
      .clock                (clock),
      .reset                (reset),
      .beat_i               (chain[NUM_INTERFACES]),
      .rsp_stall            (rsp_stall),
      .advance              (advance),
      .rsp_valid            (rsp_valid),
      .rsp_network_number   (rsp_network_number),
      .rsp_host_number      (rsp_host_number),
      .rsp_is_local         (rsp_is_local),
      .rsp_is_broadcast     (rsp_is_broadcast),
      .rsp_can_forward      (rsp_can_forward),
      .rsp_composed_address (rsp_composed_address)
   );

endmodule

// ----- sim/tb_subnet_pkg.sv -----
`timescale 1ns / 100ps
// Beat types and the interface-table shadow for the classful subnet classifier bench.
// The shadow predicts each classify and compose answer. Depends on ipcsc_pkg.
package tb_subnet_pkg;
   import ipcsc_pkg::*;

   localparam int unsigned NUM_IF = NUM_INTERFACES_DEFAULT;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef struct {
      logic [1:0]  mode;
      logic [2:0]  slot;
      logic [31:0] address;
      logic [31:0] subnet_mask;
      logic [31:0] host_bits;
      logic        bcast_ok;
      logic        enable;
   } subnet_req_type;

   typedef struct {
      logic [31:0] network;
      logic [31:0] host;
      logic        is_local;
      logic        is_bcast;
      logic        fwd_ok;
      logic [31:0] composed;
   } subnet_rsp_type;

   class iface_table_shadow_type;
      bit             subnets_local;
      bit             ent_valid[NUM_IF];
      logic [31:0]    ent_addr[NUM_IF];
      logic [31:0]    ent_cmask[NUM_IF];
      logic [31:0]    ent_smask[NUM_IF];
      bit             ent_bcast[NUM_IF];
      subnet_rsp_type due_answers[$];
      int             mismatches;

      function new();
         subnets_local = 1'b1;
         mismatches = 0;
         for (int k = 0; k < NUM_IF; k++) begin
            ent_valid[k] = 1'b0;
            ent_addr[k] = '0;
            ent_cmask[k] = '0;
            ent_smask[k] = '0;
            ent_bcast[k] = 1'b0;
         end
      endfunction

      function int owed();
         return due_answers.size();
      endfunction

      static function logic [31:0] net_mask_of(logic [31:0] a);
         logic [31:0] m;
         casez (a[31:29])
            3'b0??:  m = 32'hFF00_0000;
            3'b10?:  m = 32'hFFFF_0000;
            default: m = 32'hFFFF_FF00;
         endcase
         return m;
      endfunction

      function subnet_rsp_type classify(logic [31:0] a);
         subnet_rsp_type r;
         logic [31:0]    cm, ea, nm, sm;
         int             hit;
         cm = net_mask_of(a);
         hit = -1;
         r = '{default: '0};
         r.fwd_ok = 1'b1;
         if (a[31:29] != 3'b111) begin
            for (int k = NUM_IF - 1; k >= 0; k--)
               if (ent_valid[k] && (a & cm) == (ent_addr[k] & ent_cmask[k])) hit = k;
            if (hit >= 0) begin
               r.network = a & ent_smask[hit];
               r.host = a & ~cm & ~ent_smask[hit];
            end else begin
               r.network = a & cm;
               r.host = a & ~cm;
            end
         end else begin
            r.host = a;
         end
         for (int k = 0; k < NUM_IF; k++) begin
            if (ent_valid[k]) begin
               ea = ent_addr[k];
               nm = ent_cmask[k];
               sm = ent_smask[k];
               if (subnets_local ? ((a & nm) == (ea & nm)) : ((a & sm) == (ea & sm)))
                  r.is_local = 1'b1;
               if (ent_bcast[k] && (a == (ea & nm) || a == (ea & sm) ||
                   a == ((ea & nm) | ~nm) || a == ((ea & sm) | ~sm)))
                  r.is_bcast = 1'b1;
            end
         end
         if (a == ADDR_ANY || a == ADDR_ALL_ONES) r.is_bcast = 1'b1;
         if (a[31:28] == 4'hF) r.fwd_ok = 1'b0;
         if (!a[31] && (a[30:24] == 7'd0 || {1'b0, a[30:24]} == LOOPBACK_NET))
            r.fwd_ok = 1'b0;
         return r;
      endfunction

      function subnet_rsp_type compose(logic [31:0] a, logic [31:0] hb);
         subnet_rsp_type r;
         logic [31:0]    hm;
         int             hit;
         hm = ~net_mask_of(a);
         hit = -1;
         r = '{default: '0};
         for (int k = NUM_IF - 1; k >= 0; k--)
            if (ent_valid[k] && (ent_cmask[k] & a) == (ent_addr[k] & ent_cmask[k])) hit = k;
         if (hit >= 0) hm = ~ent_smask[hit];
         r.composed = a | (hb & hm);
         return r;
      endfunction

      function void apply_request(subnet_req_type rq);
         logic [31:0] cm;
         case (rq.mode)
            MODE_LOAD: begin
               if (rq.slot < NUM_IF) begin
                  cm = net_mask_of(rq.address);
                  ent_valid[rq.slot] = rq.enable;
                  ent_addr[rq.slot] = rq.address;
                  ent_cmask[rq.slot] = cm;
                  ent_smask[rq.slot] = rq.subnet_mask | cm;
                  ent_bcast[rq.slot] = rq.bcast_ok;
               end
            end
            MODE_CLASSIFY: due_answers.push_back(classify(rq.address));
            MODE_COMPOSE:  due_answers.push_back(compose(rq.address, rq.host_bits));
            default: ;
         endcase
      endfunction

      function void check_answer(subnet_rsp_type got);
         subnet_rsp_type exp;
         if (due_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected answer net=%h host=%h comp=%h",
                        $realtime, got.network, got.host, got.composed);
            return;
         end
         exp = due_answers.pop_front();
         if (got.network !== exp.network || got.host !== exp.host ||
             got.is_local !== exp.is_local || got.is_bcast !== exp.is_bcast ||
             got.fwd_ok !== exp.fwd_ok || got.composed !== exp.composed) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: answer mismatch", $realtime);
               $display("  exp net=%h host=%h loc=%b bc=%b fwd=%b comp=%h", exp.network,
                        exp.host, exp.is_local, exp.is_bcast, exp.fwd_ok, exp.composed);
               $display("  got net=%h host=%h loc=%b bc=%b fwd=%b comp=%h", got.network,
                        got.host, got.is_local, got.is_bcast, got.fwd_ok, got.composed);
            end
         end
      endfunction
   endclass

endpackage

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Top-level bench for ipv4_classful_subnet_classifier: directed and random beats,
// random idling on both channels. Depends on ipcsc_pkg and tb_subnet_pkg.
module tb_top;
   import ipcsc_pkg::*;
   import tb_subnet_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic        csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   logic [2:0]  req_entry_slot;
   logic [31:0] req_address;
   logic [31:0] req_subnet_mask;
   logic [31:0] req_host_bits;
   logic        req_broadcast_capable;
   logic        req_entry_enable;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_network_number;
   logic [31:0] rsp_host_number;
   logic        rsp_is_local;
   logic        rsp_is_broadcast;
   logic        rsp_can_forward;
   logic [31:0] rsp_composed_address;

   iface_table_shadow_type shadow = new();

   ipv4_classful_subnet_classifier #(
      .NUM_INTERFACES(NUM_IF)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_entry_slot       (req_entry_slot),
      .req_address          (req_address),
      .req_subnet_mask      (req_subnet_mask),
      .req_host_bits        (req_host_bits),
      .req_broadcast_capable(req_broadcast_capable),
      .req_entry_enable     (req_entry_enable),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_network_number   (rsp_network_number),
      .rsp_host_number      (rsp_host_number),
      .rsp_is_local         (rsp_is_local),
      .rsp_is_broadcast     (rsp_is_broadcast),
      .rsp_can_forward      (rsp_can_forward),
      .rsp_composed_address (rsp_composed_address)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10000000;
      $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin : watch
      subnet_req_type rq;
      subnet_rsp_type rs;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            rq.mode = req_mode;
            rq.slot = req_entry_slot;
            rq.address = req_address;
            rq.subnet_mask = req_subnet_mask;
            rq.host_bits = req_host_bits;
            rq.bcast_ok = req_broadcast_capable;
            rq.enable = req_entry_enable;
            shadow.apply_request(rq);
         end
         if (rsp_valid && !rsp_stall) begin
            rs.network = rsp_network_number;
            rs.host = rsp_host_number;
            rs.is_local = rsp_is_local;
            rs.is_bcast = rsp_is_broadcast;
            rs.fwd_ok = rsp_can_forward;
            rs.composed = rsp_composed_address;
            shadow.check_answer(rs);
         end
      end
   end

   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   initial begin : stall_gen
      int run;
      int hold;
      rsp_stall <= 1'b0;
      forever begin
         run = $urandom_range(1, 30);
         repeat (run) @(posedge clock);
         hold = pick_idle();
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [31:0] pick_mask();
      int n;
      if ($urandom_range(0, 9) < 7) begin
         n = $urandom_range(0, 32);
         return (n == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - n));
      end
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_iface_addr();
      logic [31:0] a;
      a = $urandom;
      case ($urandom_range(0, 11))
         0, 1, 2: a[31] = 1'b0;
         3, 4, 5: a[31:30] = 2'b10;
         6, 7, 8: a[31:29] = 3'b110;
         9:       a[31:28] = 4'b1110;
         10:      a[31:28] = 4'b1111;
         default: a[31:24] = $urandom_range(0, 1) ? {1'b0, LOOPBACK_NET[6:0]} : 8'd0;
      endcase
      return a;
   endfunction

   function automatic logic [31:0] pick_probe_addr();
      int          k;
      logic [31:0] ea;
      logic [31:0] nm;
      logic [31:0] sm;
      k = $urandom_range(0, NUM_IF - 1);
      ea = shadow.ent_addr[k];
      nm = shadow.ent_cmask[k];
      sm = shadow.ent_smask[k];
      case ($urandom_range(0, 9))
         0, 1:    return $urandom;
         2:       return ea;
         3, 4:    return (ea & sm) | ($urandom & ~sm);
         5:       return (ea & nm) | ($urandom & ~nm);
         6: begin
            case ($urandom_range(0, 3))
               0:       return ea & nm;
               1:       return ea & sm;
               2:       return (ea & nm) | ~nm;
               default: return (ea & sm) | ~sm;
            endcase
         end
         7:       return $urandom_range(0, 1) ? ADDR_ALL_ONES : ADDR_ANY;
         default: return pick_iface_addr();
      endcase
   endfunction

   task automatic send_beat(input subnet_req_type rq);
      int gap;
      gap = pick_idle();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= rq.mode;
      req_entry_slot <= rq.slot;
      req_address <= rq.address;
      req_subnet_mask <= rq.subnet_mask;
      req_host_bits <= rq.host_bits;
      req_broadcast_capable <= rq.bcast_ok;
      req_entry_enable <= rq.enable;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic subnet_req_type junk_beat(logic [1:0] mode, logic [31:0] a);
      subnet_req_type rq;
      rq.mode = mode;
      rq.slot = 3'($urandom);
      rq.address = a;
      rq.subnet_mask = $urandom;
      rq.host_bits = $urandom;
      rq.bcast_ok = 1'($urandom);
      rq.enable = 1'($urandom);
      return rq;
   endfunction

   task automatic load_entry(input logic [2:0] slot, input logic [31:0] a,
                             input logic [31:0] mask, input logic bc, input logic en);
      subnet_req_type rq;
      rq = junk_beat(MODE_LOAD, a);
      rq.slot = slot;
      rq.subnet_mask = mask;
      rq.bcast_ok = bc;
      rq.enable = en;
      send_beat(rq);
   endtask

   task automatic compose_beat(input logic [31:0] a, input logic [31:0] hb);
      subnet_req_type rq;
      rq = junk_beat(MODE_COMPOSE, a);
      rq.host_bits = hb;
      send_beat(rq);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (shadow.owed() != 0) @(posedge clock);
      repeat (NUM_IF + 4) @(posedge clock);
   endtask

   task automatic write_subnets_local(input logic v);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow.subnets_local = v;
   endtask

   task automatic random_beats(input int count);
      subnet_req_type rq;
      int             r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            rq = junk_beat(MODE_LOAD, pick_iface_addr());
            rq.subnet_mask = pick_mask();
            rq.enable = ($urandom_range(0, 99) < 85);
         end else if (r < 55) begin
            rq = junk_beat(MODE_CLASSIFY, pick_probe_addr());
         end else if (r < 94) begin
            rq = junk_beat(MODE_COMPOSE, pick_probe_addr());
         end else begin
            rq = junk_beat(MODE_SPARE, $urandom);
         end
         send_beat(rq);
      end
   endtask

   initial begin
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data <= 1'b0;
      req_valid <= 1'b0;
      req_mode <= MODE_LOAD;
      req_entry_slot <= '0;
      req_address <= '0;
      req_subnet_mask <= '0;
      req_host_bits <= '0;
      req_broadcast_capable <= 1'b0;
      req_entry_enable <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: overlapping class A entries, class B/C/D, a disabled entry
      load_entry(3'd0, 32'h0A01_0203, 32'hFFFF_0000, 1'b1, 1'b1);
      load_entry(3'd1, 32'h8C05_0607, 32'hFFFF_FF00, 1'b1, 1'b1);
      load_entry(3'd2, 32'hC0A8_0101, 32'h0000_0000, 1'b0, 1'b1);
      load_entry(3'd3, 32'h0A99_0000, 32'hFFFF_FF00, 1'b1, 1'b1);
      load_entry(3'd4, 32'hE000_0001, 32'hFFFF_FFFF, 1'b1, 1'b1);
      load_entry(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send_beat(junk_beat(MODE_CLASSIFY, ADDR_ANY));
      send_beat(junk_beat(MODE_CLASSIFY, ADDR_ALL_ONES));
      send_beat(junk_beat(MODE_CLASSIFY, 32'h7F00_0001));
      send_beat(junk_beat(MODE_CLASSIFY, 32'h0012_3456));
      send_beat(junk_beat(MODE_CLASSIFY, 32'hF000_0001));
      send_beat(junk_beat(MODE_CLASSIFY, 32'hE000_0005));
      send_beat(junk_beat(MODE_CLASSIFY, 32'h0AFF_FFFF));
      send_beat(junk_beat(MODE_CLASSIFY, 32'h0A01_FFFF));
      send_beat(junk_beat(MODE_CLASSIFY, 32'h0A01_0000));
      send_beat(junk_beat(MODE_CLASSIFY, 32'h0A02_0304));
      send_beat(junk_beat(MODE_CLASSIFY, 32'h8C05_06FF));
      send_beat(junk_beat(MODE_CLASSIFY, 32'hC0A8_0142));
      compose_beat(32'h0A00_0000, 32'hFFFF_FFFF);
      compose_beat(32'h8C05_0000, 32'h1234_5678);
      compose_beat(32'h2100_0000, 32'hFFFF_FFFF);
      compose_beat(32'hF000_0000, 32'hFFFF_FFFF);
      compose_beat(32'h8000_0000, 32'hAAAA_5555);
      send_beat(junk_beat(MODE_SPARE, 32'h0A01_0203));
      drain();

      // hold off between phases until every answer is back, then flip the register
      for (int ph = 0; ph < 4; ph++) begin
         write_subnets_local(ph[0]);
         random_beats(220);
         drain();
      end

      if (shadow.mismatches == 0 && shadow.owed() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/ipcsc_pkg.sv
sv/ipcsc_cell.sv
sv/ipcsc_out.sv
sv/ipv4_classful_subnet_classifier.sv
sim/tb_subnet_pkg.sv
sim/tb_top.sv
